@@ design/sicr_pkg.sv @@
// Shared types, fixed-point constants and helpers for the sea ice retrieval.
// Used by every module of the block but sicr_div; depends on nothing.
package sicr_pkg;

  typedef logic signed [31:0] sq_t;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_LOWLAT = 3'd1;
  localparam logic [2:0] ST_BELOW  = 3'd2;
  localparam logic [2:0] ST_LAND   = 3'd3;
  localparam logic [2:0] ST_EDGE   = 3'd4;

  localparam logic [1:0] ICE_LO  = 2'd0;
  localparam logic [1:0] ICE_MID = 2'd1;
  localparam logic [1:0] ICE_HI  = 2'd2;

  localparam logic [1:0] REG_CUTOFF = 2'd0;
  localparam logic [1:0] REG_UPPER  = 2'd1;
  localparam logic [1:0] REG_LOWER  = 2'd2;

  localparam logic [20:0] Q_ONE = 21'h100000;

  localparam sq_t K_A0 = 32'sd152114823;
  localparam sq_t K_A1 = 32'sd252044;
  localparam sq_t K_A2 = 32'sd189639;
  localparam sq_t K_A3 = 32'sd12078998;
  localparam sq_t K_W0 = 32'sd191260;
  localparam sq_t K_W1 = 32'sd948752;
  localparam sq_t K_W2 = 32'sd652319;
  localparam sq_t K_E0 = 32'sd1929380;
  localparam sq_t K_EU = 32'sd758120;
  localparam sq_t K_B  = -32'sd923;
  localparam sq_t K_C0 = 32'sd6921;
  localparam sq_t K_CU = 32'sd3041;
  localparam sq_t K_D  = -32'sd9710;
  localparam sq_t K_ICE_LO  = 32'sd975176;
  localparam sq_t K_ICE_MID = 32'sd912261;
  localparam sq_t K_ICE_HI  = 32'sd870318;

  localparam logic [12:0] ZEN_MAX = 13'd8000;
  localparam logic signed [14:0] LAT_LIMIT = 15'sd5000;

  typedef struct packed {
    logic [11:0]        scan_line;
    logic [4:0]         fov;
    logic [2:0]         status;
    logic [12:0]        zen;
    logic signed [17:0] t23h;
    logic signed [17:0] t31h;
    logic [1:0]         ice;
  } item_t;

  typedef struct packed {
    item_t       item;
    logic [20:0] u;
  } cos_res_t;

  typedef struct packed {
    item_t item;
    logic  neg;
  } quo_tag_t;

  typedef struct packed {
    logic [13:0] cutoff;
    logic [13:0] upper;
    logic [13:0] lower;
  } cfg_t;

  typedef struct packed {
    logic [11:0] scan_line;
    logic [4:0]  fov;
    logic [2:0]  status;
    logic [13:0] conc;
  } result_t;

  // Q20 product, truncated toward zero
  function automatic sq_t qmul(input sq_t a, input sq_t b);
    logic signed [63:0] p;
    logic signed [63:0] r;
    p = 64'(a) * 64'(b);
    if (p < 0) begin
      r = -((-p) >>> 20);
    end else begin
      r = p >>> 20;
    end
    return 32'(r);
  endfunction

  function automatic sq_t ice_val(input logic [1:0] code);
    sq_t v;
    case (code)
      ICE_LO:  v = K_ICE_LO;
      ICE_MID: v = K_ICE_MID;
      default: v = K_ICE_HI;
    endcase
    return v;
  endfunction

endpackage

@@ design/sea_ice_concentration_retrieval.sv @@
// Sea ice concentration retrieval, top level. Throughput: one field of view per
// cycle while the output register is empty or popped; the arithmetic pipeline and
// its two one-bit-per-stage dividers set the latency, not the rate.
// Reset (synchronous, rst_n low) empties every stage and queue and loads the
// register defaults: cutoff 1500, upper limit 10000, lower limit 0.
module sea_ice_concentration_retrieval #(
  parameter int SPOTS = 30
) (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                push,
  output logic                full,
  input  logic [11:0]         in_scan_line,
  input  logic [4:0]          in_fov_index,
  input  logic [7:0]          in_surface_type,
  input  logic signed [14:0]  in_latitude,
  input  logic [12:0]         in_zenith_angle,
  input  logic [15:0]         in_tb23_raw,
  input  logic [15:0]         in_tb31_raw,
  input  logic signed [11:0]  in_tb23_correction,
  input  logic signed [11:0]  in_tb31_correction,
  // result channel
  output logic                empty,
  input  logic                pop,
  output logic [11:0]         out_scan_line_out,
  output logic [4:0]          out_fov_out,
  output logic [2:0]          out_status,
  output logic [13:0]         out_concentration,
  // configuration
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [13:0]         cfg_wdata
);

  sicr_pkg::cfg_t    cfg_r;

  // Configuration registers: write-only, taken on any edge with cfg_we high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cutoff <= 14'd1500;
      cfg_r.upper  <= 14'd10000;
      cfg_r.lower  <= 14'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        sicr_pkg::REG_CUTOFF: cfg_r.cutoff <= cfg_wdata;
        sicr_pkg::REG_UPPER:  cfg_r.upper  <= cfg_wdata;
        sicr_pkg::REG_LOWER:  cfg_r.lower  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Front: correct, saturate and classify, then hand over to the queue.
  logic            fr_v;
  sicr_pkg::item_t fr_item;
  logic            q_full;
  logic            q_empty;
  sicr_pkg::item_t q_item;
  logic            back_en;

  sicr_front #(.SPOTS(SPOTS)) u_front (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full),
    .in_scan_line(in_scan_line), .in_fov_index(in_fov_index),
    .in_surface_type(in_surface_type), .in_latitude(in_latitude),
    .in_zenith_angle(in_zenith_angle), .in_tb23_raw(in_tb23_raw),
    .in_tb31_raw(in_tb31_raw), .in_tb23_correction(in_tb23_correction),
    .in_tb31_correction(in_tb31_correction),
    .item_valid(fr_v), .item(fr_item), .q_full(q_full)
  );

  // The queue lets the front keep taking transfers while the back end holds.
  sicr_queue #(.DEPTH(4)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_en(fr_v), .wr_item(fr_item), .q_full(q_full),
    .rd_en(back_en), .q_empty(q_empty), .rd_item(q_item)
  );

  // Back end advances as one whole whenever the output register can take
  // its last stage: when that register is empty or being popped.
  logic              out_v_r;
  sicr_pkg::result_t out_res_r;
  logic              back_v;
  sicr_pkg::result_t back_res;

  assign back_en = !out_v_r || pop;

  sicr_back u_back (
    .clk(clk), .rst_n(rst_n), .en(back_en),
    .in_valid(!q_empty), .in_item(q_item), .cfg(cfg_r),
    .out_valid(back_v), .out_res(back_res)
  );

  // Output register: hold the oldest result until it is popped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (back_en) begin
      out_v_r <= back_v;
    end
  end

  always_ff @(posedge clk) begin
    if (back_en && back_v) begin
      out_res_r <= back_res;
    end
  end

  assign empty             = !out_v_r;
  assign out_scan_line_out = out_res_r.scan_line;
  assign out_fov_out       = out_res_r.fov;
  assign out_status        = out_res_r.status;
  assign out_concentration = out_res_r.conc;

endmodule

@@ design/sicr_front.sv @@
// Front stage: takes a field of view, applies corrections and classifies it.
// Depends on sicr_pkg.
module sicr_front #(
  parameter int SPOTS = 30
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic [11:0]           in_scan_line,
  input  logic [4:0]            in_fov_index,
  input  logic [7:0]            in_surface_type,
  input  logic signed [14:0]    in_latitude,
  input  logic [12:0]           in_zenith_angle,
  input  logic [15:0]           in_tb23_raw,
  input  logic [15:0]           in_tb31_raw,
  input  logic signed [11:0]    in_tb23_correction,
  input  logic signed [11:0]    in_tb31_correction,
  output logic                  item_valid,
  output sicr_pkg::item_t       item,
  input  logic                  q_full
);

  logic              fr_v_r;
  sicr_pkg::item_t   item_r;
  sicr_pkg::item_t   item_nxt;
  logic              advance;
  logic signed [18:0] diff;
  logic              is_edge;

  assign advance = !fr_v_r || !q_full;
  assign full    = !advance;

  assign is_edge = (in_fov_index < 5'd2) ||
                   (({4'b0, in_fov_index} + 9'd2) >= 9'(SPOTS));

  always_comb begin
    item_nxt.scan_line = in_scan_line;
    item_nxt.fov       = in_fov_index;
    item_nxt.t23h      = $signed({2'b00, in_tb23_raw}) + 18'(in_tb23_correction);
    item_nxt.t31h      = $signed({2'b00, in_tb31_raw}) + 18'(in_tb31_correction);
    item_nxt.zen       = (in_zenith_angle > sicr_pkg::ZEN_MAX) ? sicr_pkg::ZEN_MAX
                                                              : in_zenith_angle;
    diff = 19'(item_nxt.t23h) - 19'(item_nxt.t31h);
    if (diff < 19'sd500) begin
      item_nxt.ice = sicr_pkg::ICE_LO;
    end else if (diff <= 19'sd1000) begin
      item_nxt.ice = sicr_pkg::ICE_MID;
    end else begin
      item_nxt.ice = sicr_pkg::ICE_HI;
    end
    if (is_edge) begin
      item_nxt.status = sicr_pkg::ST_EDGE;
    end else if (in_surface_type != 8'd0) begin
      item_nxt.status = sicr_pkg::ST_LAND;
    end else if (in_latitude < sicr_pkg::LAT_LIMIT && in_latitude > -sicr_pkg::LAT_LIMIT) begin
      item_nxt.status = sicr_pkg::ST_LOWLAT;
    end else begin
      item_nxt.status = sicr_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_v_r <= 1'b0;
    end else if (advance) begin
      fr_v_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && push) begin
      item_r <= item_nxt;
    end
  end

  assign item_valid = fr_v_r;
  assign item       = item_r;

endmodule

@@ design/sicr_queue.sv @@
// Short register queue between the front stage and the arithmetic back end.
// Depends on sicr_pkg.
module sicr_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  sicr_pkg::item_t wr_item,
  output logic            q_full,
  input  logic            rd_en,
  output logic            q_empty,
  output sicr_pkg::item_t rd_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  sicr_pkg::item_t mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [AW:0]     cnt_r;
  logic            do_wr;
  logic            do_rd;

  assign q_full  = (cnt_r == (AW+1)'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_item = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

@@ design/sicr_cos.sv @@
// Pipelined cosine of the zenith angle by a truncated series in Q20.
// Constant divisions use rounded reciprocal products. Depends on sicr_pkg.
module sicr_cos (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  sicr_pkg::item_t in_item,
  output logic            out_valid,
  output sicr_pkg::item_t out_item,
  output logic [20:0]     out_u
);

  localparam int STAGES = 12;
  localparam logic [17:0] K_RAD  = 18'd183011;
  localparam logic [31:0] M1000  = 32'd2199023256;
  localparam logic [24:0] M90    = 25'd23860930;
  localparam logic [24:0] M56    = 25'd19173962;
  localparam logic [24:0] M30    = 25'd17895698;
  localparam logic [24:0] M12    = 25'd22369622;

  logic [STAGES-1:0] vld_r;
  sicr_pkg::item_t   item_r [STAGES];
  logic [30:0]       p0_r;
  logic [20:0]       x_r;
  logic [21:0]       x2_r [8];
  logic [20:0]       t1_r, t2_r, t3_r, t4_r;
  logic [21:0]       p1_r, p2_r, p3_r, p4_r;
  logic [20:0]       u_r;

  logic [62:0] xm;
  logic [41:0] xx;
  logic [46:0] m90, m56, m30, m12;
  logic [42:0] pp1, pp2, pp3, pp4;
  logic [21:0] u_s;

  assign xm  = 63'(p0_r) * 63'(M1000);
  assign xx  = 42'(x_r) * 42'(x_r);
  assign m90 = 47'(x2_r[0]) * 47'(M90);
  assign pp1 = 43'(x2_r[1]) * 43'(t1_r);
  assign m56 = 47'(p1_r) * 47'(M56);
  assign pp2 = 43'(x2_r[3]) * 43'(t2_r);
  assign m30 = 47'(p2_r) * 47'(M30);
  assign pp3 = 43'(x2_r[5]) * 43'(t3_r);
  assign m12 = 47'(p3_r) * 47'(M12);
  assign pp4 = 43'(x2_r[7]) * 43'(t4_r);
  assign u_s = 22'(sicr_pkg::Q_ONE) - 22'(p4_r[21:1]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STAGES-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      item_r[0] <= in_item;
      for (int i = 1; i < STAGES; i++) begin
        item_r[i] <= item_r[i-1];
      end
      p0_r     <= 31'(in_item.zen) * 31'(K_RAD);
      x_r      <= xm[61:41];
      x2_r[0]  <= xx[41:20];
      for (int i = 1; i < 8; i++) begin
        x2_r[i] <= x2_r[i-1];
      end
      t1_r <= sicr_pkg::Q_ONE - 21'(m90[46:31]);
      p1_r <= pp1[41:20];
      t2_r <= sicr_pkg::Q_ONE - 21'(m56[46:30]);
      p2_r <= pp2[41:20];
      t3_r <= sicr_pkg::Q_ONE - 21'(m30[46:29]);
      p3_r <= pp3[41:20];
      t4_r <= sicr_pkg::Q_ONE - 21'(m12[46:28]);
      p4_r <= pp4[41:20];
      u_r  <= (u_s[21] || u_s == '0) ? 21'd1 : u_s[20:0];
    end
  end

  assign out_valid = vld_r[STAGES-1];
  assign out_item  = item_r[STAGES-1];
  assign out_u     = u_r;

endmodule

@@ design/sicr_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// The caller guarantees num >> Q_W is below den. No package dependence.
module sicr_div #(
  parameter int NUM_W = 40,
  parameter int DEN_W = 21,
  parameter int Q_W   = 22,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] in_den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [Q_W-1:0]   out_q,
  output logic [TAG_W-1:0] out_tag
);

  logic [Q_W-1:0]   vld_r;
  logic [DEN_W-1:0] rem_r [Q_W];
  logic [DEN_W-1:0] den_r [Q_W];
  logic [Q_W-1:0]   low_r [Q_W];
  logic [Q_W-1:0]   q_r   [Q_W];
  logic [TAG_W-1:0] tag_r [Q_W];

  for (genvar i = 0; i < Q_W; i++) begin : g_step
    logic             vld_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [Q_W-1:0]   low_in;
    logic [Q_W-1:0]   q_in;
    logic [TAG_W-1:0] tag_in;
    logic [DEN_W:0]   trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign vld_in = in_valid;
      assign rem_in = DEN_W'(in_num >> Q_W);
      assign den_in = in_den;
      assign low_in = in_num[Q_W-1:0];
      assign q_in   = '0;
      assign tag_in = in_tag;
    end else begin : g_next
      assign vld_in = vld_r[i-1];
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign low_in = low_r[i-1];
      assign q_in   = q_r[i-1];
      assign tag_in = tag_r[i-1];
    end

    assign trial = {rem_in, low_in[Q_W-1]};
    assign ge    = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
        den_r[i] <= den_in;
        low_r[i] <= {low_in[Q_W-2:0], 1'b0};
        q_r[i]   <= {q_in[Q_W-2:0], ge};
        tag_r[i] <= tag_in;
      end
    end
  end

  assign out_valid = vld_r[Q_W-1];
  assign out_q     = q_r[Q_W-1];
  assign out_tag   = tag_r[Q_W-1];

endmodule

@@ design/sicr_back.sv @@
// Arithmetic back end: cosine, 1/cos, regression, emissivities, division and limits.
// Depends on sicr_pkg, sicr_cos and sicr_div.
module sicr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  sicr_pkg::item_t   in_item,
  input  sicr_pkg::cfg_t    cfg,
  output logic              out_valid,
  output sicr_pkg::result_t out_res
);

  localparam int COS_W = $bits(sicr_pkg::cos_res_t);
  localparam int QT_W  = $bits(sicr_pkg::quo_tag_t);
  localparam logic [42:0] M25 = 43'd2684355;

  // cosine
  logic              cos_v;
  sicr_pkg::item_t   cos_item;
  logic [20:0]       cos_u;
  sicr_pkg::cos_res_t cos_res;

  sicr_cos u_cos (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(in_valid), .in_item(in_item),
    .out_valid(cos_v), .out_item(cos_item), .out_u(cos_u)
  );

  assign cos_res.item = cos_item;
  assign cos_res.u    = cos_u;

  // 2^40 / u
  logic               d1_v;
  logic [23:0]        d1_q;
  logic [COS_W-1:0]   d1_tag;
  sicr_pkg::cos_res_t d1_res;

  sicr_div #(.NUM_W(41), .DEN_W(21), .Q_W(24), .TAG_W(COS_W)) u_inv (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(cos_v), .in_num(41'h1 << 40), .in_den(cos_u), .in_tag(cos_res),
    .out_valid(d1_v), .out_q(d1_q), .out_tag(d1_tag)
  );

  assign d1_res = d1_tag;

  logic [6:0] sv_r;
  logic [1:0] fv_r;

  // stage 1
  sicr_pkg::item_t s1_item_r;
  sicr_pkg::sq_t   s1_uu_r, s1_w1u_r, s1_eu_r, s1_cu_r, s1_a3i_r;
  logic            s1_n23_r, s1_n31_r;
  logic [30:0]     s1_a23_r, s1_a31_r;
  logic [20:0]     s1_b23_r, s1_b31_r;
  // stage 2
  sicr_pkg::item_t s2_item_r;
  sicr_pkg::sq_t   s2_w1u_r, s2_w2uu_r, s2_a3i_r, s2_t23_r, s2_t31_r, s2_a_r, s2_c_r;
  // stage 3
  sicr_pkg::item_t s3_item_r;
  sicr_pkg::sq_t   s3_epsw_r, s3_bt23_r, s3_ct31_r, s3_a1_r, s3_a2_r, s3_a_r, s3_a3i_r;
  // stage 4
  sicr_pkg::item_t s4_item_r;
  sicr_pkg::sq_t   s4_epart_r, s4_t50_r, s4_epsw_r;
  logic [20:0]     s4_den_r;
  // stage 5
  sicr_pkg::item_t s5_item_r;
  sicr_pkg::sq_t   s5_epart_r, s5_dt50_r, s5_epsw_r;
  logic [20:0]     s5_den_r;
  // stage 6
  sicr_pkg::item_t s6_item_r;
  sicr_pkg::sq_t   s6_nd_r;
  logic [20:0]     s6_den_r;
  // stage 7
  sicr_pkg::quo_tag_t s7_tag_r;
  logic [39:0]        s7_mag_r;
  logic [20:0]        s7_den_r;

  sicr_pkg::sq_t   u_s, inv_s;
  logic [16:0]     h23, h31;
  logic [42:0]     m23, m31;
  logic [30:0]     v23, v31;
  sicr_pkg::sq_t   den_s;
  logic signed [63:0] prod;

  assign u_s   = sicr_pkg::sq_t'({11'b0, d1_res.u});
  assign inv_s = sicr_pkg::sq_t'({8'b0, d1_q});
  assign h23   = d1_res.item.t23h[17] ? 17'(-d1_res.item.t23h) : d1_res.item.t23h[16:0];
  assign h31   = d1_res.item.t31h[17] ? 17'(-d1_res.item.t31h) : d1_res.item.t31h[16:0];
  assign m23   = 43'(s1_b23_r) * M25;
  assign m31   = 43'(s1_b31_r) * M25;
  assign v23   = s1_a23_r + 31'(m23[42:26]);
  assign v31   = s1_a31_r + 31'(m31[42:26]);
  assign den_s = sicr_pkg::ice_val(s3_item_r.ice) - s3_epsw_r;
  assign prod  = 64'(s6_nd_r) * 64'sd10000;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= '0;
    end else if (en) begin
      sv_r <= {sv_r[5:0], d1_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_item_r <= d1_res.item;
      s1_uu_r   <= sicr_pkg::qmul(u_s, u_s);
      s1_w1u_r  <= sicr_pkg::qmul(sicr_pkg::K_W1, u_s);
      s1_eu_r   <= sicr_pkg::qmul(sicr_pkg::K_EU, u_s);
      s1_cu_r   <= sicr_pkg::qmul(sicr_pkg::K_CU, u_s);
      s1_a3i_r  <= sicr_pkg::qmul(sicr_pkg::K_A3, inv_s);
      s1_n23_r  <= d1_res.item.t23h[17];
      s1_n31_r  <= d1_res.item.t31h[17];
      s1_a23_r  <= 31'(h23) * 31'd10485;
      s1_a31_r  <= 31'(h31) * 31'd10485;
      s1_b23_r  <= 21'(h23) * 21'd19;
      s1_b31_r  <= 21'(h31) * 21'd19;

      s2_item_r <= s1_item_r;
      s2_w1u_r  <= s1_w1u_r;
      s2_w2uu_r <= sicr_pkg::qmul(sicr_pkg::K_W2, s1_uu_r);
      s2_a3i_r  <= s1_a3i_r;
      s2_t23_r  <= s1_n23_r ? -sicr_pkg::sq_t'({1'b0, v23}) : sicr_pkg::sq_t'({1'b0, v23});
      s2_t31_r  <= s1_n31_r ? -sicr_pkg::sq_t'({1'b0, v31}) : sicr_pkg::sq_t'({1'b0, v31});
      s2_a_r    <= sicr_pkg::K_E0 - s1_eu_r;
      s2_c_r    <= sicr_pkg::K_C0 + s1_cu_r;

      s3_item_r <= s2_item_r;
      s3_epsw_r <= sicr_pkg::K_W0 + s2_w1u_r - s2_w2uu_r;
      s3_bt23_r <= sicr_pkg::qmul(sicr_pkg::K_B, s2_t23_r);
      s3_ct31_r <= sicr_pkg::qmul(s2_c_r, s2_t31_r);
      s3_a1_r   <= sicr_pkg::qmul(sicr_pkg::K_A1, s2_t23_r);
      s3_a2_r   <= sicr_pkg::qmul(sicr_pkg::K_A2, s2_t31_r);
      s3_a_r    <= s2_a_r;
      s3_a3i_r  <= s2_a3i_r;

      s4_item_r  <= s3_item_r;
      s4_epart_r <= s3_a_r + s3_bt23_r + s3_ct31_r;
      s4_t50_r   <= sicr_pkg::K_A0 + s3_a1_r + s3_a2_r + s3_a3i_r;
      s4_epsw_r  <= s3_epsw_r;
      // a non-positive denominator falls back to one LSB
      s4_den_r   <= (den_s <= 0) ? 21'd1 : den_s[20:0];

      s5_item_r  <= s4_item_r;
      s5_epart_r <= s4_epart_r;
      s5_dt50_r  <= sicr_pkg::qmul(sicr_pkg::K_D, s4_t50_r);
      s5_epsw_r  <= s4_epsw_r;
      s5_den_r   <= s4_den_r;

      s6_item_r <= s5_item_r;
      s6_nd_r   <= s5_epart_r + s5_dt50_r - s5_epsw_r;
      s6_den_r  <= s5_den_r;

      s7_tag_r.item <= s6_item_r;
      s7_tag_r.neg  <= prod[63];
      s7_mag_r      <= prod[63] ? 40'(-prod) : prod[39:0];
      s7_den_r      <= s6_den_r;
    end
  end

  // signed quotient by magnitude, truncating toward zero
  logic               d2_v;
  logic [21:0]        d2_q;
  logic [QT_W-1:0]    d2_tag;
  sicr_pkg::quo_tag_t d2_res;

  sicr_div #(.NUM_W(40), .DEN_W(21), .Q_W(22), .TAG_W(QT_W)) u_quo (
    .clk(clk), .rst_n(rst_n), .en(en),
    .in_valid(sv_r[6]), .in_num(s7_mag_r), .in_den(s7_den_r), .in_tag(s7_tag_r),
    .out_valid(d2_v), .out_q(d2_q), .out_tag(d2_tag)
  );

  assign d2_res = d2_tag;

  sicr_pkg::item_t    s8_item_r;
  logic signed [22:0] s8_f_r;
  sicr_pkg::result_t  s9_res_r;

  logic signed [22:0] f_s;
  logic signed [22:0] f2;

  assign f_s = d2_res.neg ? -$signed({1'b0, d2_q}) : $signed({1'b0, d2_q});
  assign f2  = (s8_f_r > $signed({9'b0, cfg.upper})) ? $signed({9'b0, cfg.upper}) : s8_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= '0;
    end else if (en) begin
      fv_r <= {fv_r[0], d2_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s8_item_r <= d2_res.item;
      s8_f_r    <= (f_s < $signed({9'b0, cfg.cutoff})) ? 23'sd0 : f_s;

      s9_res_r.scan_line <= s8_item_r.scan_line;
      s9_res_r.fov       <= s8_item_r.fov;
      if (s8_item_r.status != sicr_pkg::ST_OK) begin
        s9_res_r.status <= s8_item_r.status;
        s9_res_r.conc   <= '0;
      end else if (f2 < $signed({9'b0, cfg.lower})) begin
        s9_res_r.status <= sicr_pkg::ST_BELOW;
        s9_res_r.conc   <= '0;
      end else begin
        s9_res_r.status <= sicr_pkg::ST_OK;
        s9_res_r.conc   <= f2[22] ? 14'd0 : f2[13:0];
      end
    end
  end

  assign out_valid = fv_r[1];
  assign out_res   = s9_res_r;

endmodule
